// ===== hw/rtl/btlv_pkg.sv =====
// Shared types and constants for the BER TLV header parser.
package btlv_pkg;

  // Width of the length accumulator
  localparam int LEN_BITS = 32;
  // Width used when the accumulator is compared with byte counts
  localparam int ACC_W = (LEN_BITS > 32) ? LEN_BITS : 32;

  localparam logic [4:0] TAG_LONG_MARK = 5'h1f;
  localparam logic [7:0] COUNT_MAX     = 8'hff;
  localparam logic [7:0] LEN_COUNT_MAX = 8'd128;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TAG   = 3'd1,
    PH_LEN1  = 3'd2,
    PH_LENN  = 3'd3,
    PH_VAL   = 3'd4,
    PH_TRAIL = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_TAG   = 2'd0,
    ROLE_LEN   = 2'd1,
    ROLE_VAL   = 2'd2,
    ROLE_TRAIL = 2'd3
  } role_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TAG_END  = 3'd1,
    ST_NO_LEN   = 3'd2,
    ST_LEN_END  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_VAL_LONG = 3'd5
  } status_t;

  // One input byte with its buffer markers
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic [31:0] buffer_bytes;
  } item_t;

  // One result item
  typedef struct packed {
    role_t       role;
    logic        done_res;
    status_t     status;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [7:0]  tag_count;
    logic [7:0]  length_count;
    logic [31:0] length_value;
  } result_t;

endpackage

// ===== hw/rtl/btlv_in_reg.sv =====
// Input register stage: holds one accepted byte until the parse core takes it.
module btlv_in_reg
  import btlv_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  byte_valid,
  output logic  byte_stall,
  input  item_t item,
  input  logic  advance,
  output logic  q_valid,
  output item_t q_item
);

  // Hold the byte while the result side cannot take it
  assign byte_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!byte_stall) begin
      q_valid <= byte_valid;
    end
  end

  // Load the payload on every transfer
  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      q_item <= item;
    end
  end

endmodule

// ===== hw/rtl/btlv_core.sv =====
// Parse core: parser state registers and the per-byte update logic.
module btlv_core
  import btlv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  phase_t               phase, phase_next;
  logic [31:0]          bytes_left, bytes_left_next;
  logic [7:0]           tag_seen, tag_seen_next;
  logic [7:0]           length_seen, length_seen_next;
  logic [6:0]           length_to_go, length_to_go_next;
  logic [LEN_BITS-1:0]  length_acc, length_acc_next;
  logic [31:0]          value_left, value_left_next;
  logic [1:0]           class_bits, class_bits_next;
  logic                 constructed_bit, constructed_bit_next;
  status_t              last_status, last_status_next;

  logic [7:0]           b;
  logic [31:0]          left_dec;
  logic [31:0]          value_dec;
  logic [6:0]           to_go_dec;
  logic [LEN_BITS-1:0]  shifted;
  logic [LEN_BITS-1:0]  cand;
  logic [ACC_W-1:0]     cand_ext;
  logic [ACC_W-1:0]     acc_ext;
  logic                 fin;
  status_t              fin_code;
  logic                 settle;
  role_t                role;

  assign b         = item.data_byte;
  assign left_dec  = (bytes_left == 32'd0) ? 32'd0 : bytes_left - 32'd1;
  assign value_dec = (value_left == 32'd0) ? 32'd0 : value_left - 32'd1;
  assign to_go_dec = (length_to_go == 7'd0) ? 7'd0 : length_to_go - 7'd1;
  assign shifted   = (length_acc << 8) | LEN_BITS'(b);
  // Candidate length for the settle check: short form byte or shifted long form
  assign cand      = (phase == PH_LEN1) ? (b[7] ? '0 : LEN_BITS'(b)) : shifted;
  assign cand_ext  = ACC_W'(cand);

  // Compute the next state for one byte
  always_comb begin
    phase_next           = phase;
    bytes_left_next      = bytes_left;
    tag_seen_next        = tag_seen;
    length_seen_next     = length_seen;
    length_to_go_next    = length_to_go;
    length_acc_next      = length_acc;
    value_left_next      = value_left;
    class_bits_next      = class_bits;
    constructed_bit_next = constructed_bit;
    last_status_next     = last_status;
    fin                  = 1'b0;
    fin_code             = ST_OK;
    settle               = 1'b0;
    role                 = ROLE_TRAIL;

    if (item.first) begin
      // Restart: clear everything and take the first tag byte, unless the buffer is empty
      bytes_left_next      = '0;
      tag_seen_next        = '0;
      length_seen_next     = '0;
      length_to_go_next    = '0;
      length_acc_next      = '0;
      value_left_next      = '0;
      class_bits_next      = '0;
      constructed_bit_next = 1'b0;
      last_status_next     = ST_OK;
      if (item.buffer_bytes == 32'd0) begin
        phase_next = PH_TRAIL;
      end else begin
        bytes_left_next      = item.buffer_bytes - 32'd1;
        role                 = ROLE_TAG;
        tag_seen_next        = 8'd1;
        class_bits_next      = b[7:6];
        constructed_bit_next = b[5];
        if (b[4:0] == TAG_LONG_MARK) begin
          if (item.buffer_bytes == 32'd1) begin
            fin = 1'b1; fin_code = ST_TAG_END;
          end else begin
            phase_next = PH_TAG;
          end
        end else begin
          if (item.buffer_bytes == 32'd1) begin
            fin = 1'b1; fin_code = ST_NO_LEN;
          end else begin
            phase_next = PH_LEN1;
          end
        end
      end
    end else begin
      case (phase)
        PH_TAG: begin
          role            = ROLE_TAG;
          bytes_left_next = left_dec;
          if (tag_seen != COUNT_MAX) tag_seen_next = tag_seen + 8'd1;
          if (b[7]) begin
            if (left_dec == 32'd0) begin
              fin = 1'b1; fin_code = ST_TAG_END;
            end
          end else if (left_dec == 32'd0) begin
            fin = 1'b1; fin_code = ST_NO_LEN;
          end else begin
            phase_next = PH_LEN1;
          end
        end
        PH_LEN1: begin
          role             = ROLE_LEN;
          bytes_left_next  = left_dec;
          length_seen_next = 8'd1;
          if (!b[7]) begin
            length_acc_next = cand;
            settle          = 1'b1;
          end else if (32'(b[6:0]) > left_dec) begin
            fin = 1'b1; fin_code = ST_LEN_END;
          end else if (b[6:0] == 7'd0) begin
            length_acc_next = '0;
            settle          = 1'b1;
          end else begin
            length_to_go_next = b[6:0];
            length_acc_next   = '0;
            phase_next        = PH_LENN;
          end
        end
        PH_LENN: begin
          role            = ROLE_LEN;
          bytes_left_next = left_dec;
          if (length_seen != COUNT_MAX) length_seen_next = length_seen + 8'd1;
          if (length_seen != 8'd1 && length_acc[LEN_BITS-1 -: 8] != 8'd0) begin
            fin = 1'b1; fin_code = ST_OVERFLOW;
          end else begin
            length_acc_next   = shifted;
            length_to_go_next = to_go_dec;
            if (to_go_dec == 7'd0) settle = 1'b1;
          end
        end
        PH_VAL: begin
          role            = ROLE_VAL;
          bytes_left_next = left_dec;
          value_left_next = value_dec;
          if (value_dec == 32'd0) begin
            fin = 1'b1; fin_code = ST_OK;
          end
        end
        default: begin
          role = ROLE_TRAIL;
        end
      endcase
    end

    // Check the decoded length against the rest of the buffer
    if (settle) begin
      if (cand_ext > ACC_W'(left_dec)) begin
        fin = 1'b1; fin_code = ST_VAL_LONG;
      end else if (cand == '0) begin
        fin = 1'b1; fin_code = ST_OK;
      end else begin
        value_left_next = cand_ext[31:0];
        phase_next      = PH_VAL;
      end
    end

    // Close the parse on completion or error
    if (fin) begin
      phase_next       = PH_TRAIL;
      last_status_next = fin_code;
    end
  end

  assign acc_ext = ACC_W'(length_acc_next);

  // Build the result from the updated state
  always_comb begin
    res.role         = role;
    res.done_res     = fin;
    res.status       = last_status_next;
    res.tag_class    = class_bits_next;
    res.constructed  = constructed_bit_next;
    res.tag_count    = tag_seen_next;
    res.length_count = length_seen_next;
    res.length_value = acc_ext[31:0];
  end

  // Advance the state on each byte taken from the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bytes_left      <= '0;
      tag_seen        <= '0;
      length_seen     <= '0;
      length_to_go    <= '0;
      length_acc      <= '0;
      value_left      <= '0;
      class_bits      <= '0;
      constructed_bit <= 1'b0;
      last_status     <= ST_OK;
    end else if (fire) begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      tag_seen        <= tag_seen_next;
      length_seen     <= length_seen_next;
      length_to_go    <= length_to_go_next;
      length_acc      <= length_acc_next;
      value_left      <= value_left_next;
      class_bits      <= class_bits_next;
      constructed_bit <= constructed_bit_next;
      last_status     <= last_status_next;
    end
  end

endmodule

// ===== hw/rtl/btlv_out_reg.sv =====
// Result register stage: holds one result until the receiver takes it.
module btlv_out_reg
  import btlv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    advance,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t res_q
);

  // The register can take a new result when empty or being drained
  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= load;
    end
  end

  // Load the payload; hold it while stalled
  always_ff @(posedge clk) begin
    if (load && advance) begin
      res_q <= res_in;
    end
  end

endmodule

// ===== hw/rtl/ber_tlv_header_parser.sv =====
// Top level of the BER TLV header parser: input register, parse core, result register.
//
// Usage: feed the buffer one byte per transfer on the byte channel
// (byte_valid / byte_stall, payload data_byte, first, buffer_bytes). Set first
// on the first byte of each buffer together with its total byte count; first
// restarts the parse at any time. Every byte yields exactly one result on the
// result channel (result_valid / result_stall): its role, a done flag, the
// running status and the header fields decoded so far.
// A transferred byte waits in the input register, is parsed as its result is
// loaded into the result register, and transfers from there. Throughput is
// one byte per clock unless the receiver stalls; the parser state update is a
// single pass of logic between the input register and the result register.
// Reset (rst, synchronous) empties both registers and returns the parser to
// idle; bytes without first are then reported as trailing with status ok.
// When the receiver stalls, the result holds, a full input register keeps its
// byte and raises byte_stall in the same cycle, so that no byte is lost.
module ber_tlv_header_parser
  import btlv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        first,
  input  logic [31:0] buffer_bytes,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  role,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [1:0]  tag_class,
  output logic        constructed,
  output logic [7:0]  tag_count,
  output logic [7:0]  length_count,
  output logic [31:0] length_value
);

  item_t   item;
  item_t   q_item;
  logic    q_valid;
  logic    advance;
  logic    fire;
  result_t res_next;
  result_t res_q;

  assign item.data_byte    = data_byte;
  assign item.first        = first;
  assign item.buffer_bytes = buffer_bytes;

  // Parse a byte when the input register holds one and the result register can take it
  assign fire = q_valid && advance;

  btlv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .item       (item),
    .advance    (advance),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  btlv_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (q_item),
    .res  (res_next)
  );

  btlv_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (q_valid),
    .res_in       (res_next),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res_q        (res_q)
  );

  assign role         = res_q.role;
  assign done_res     = res_q.done_res;
  assign status       = res_q.status;
  assign tag_class    = res_q.tag_class;
  assign constructed  = res_q.constructed;
  assign tag_count    = res_q.tag_count;
  assign length_count = res_q.length_count;
  assign length_value = res_q.length_value;

  // A completing or failing byte is always part of the header or value
  a_done_not_trailing: assert property (@(posedge clk) disable iff (rst)
    result_valid && done_res |-> role != ROLE_TRAIL)
    else $error("done flagged on a trailing byte");

  // An error status is only possible once a tag byte was seen
  a_error_after_tag: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> tag_count != 8'd0)
    else $error("error status without a tag byte");

  // Length bytes are counted on every length byte and never exceed the long form limit
  a_length_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && role == ROLE_LEN |-> length_count != 8'd0 &&
    length_count <= LEN_COUNT_MAX)
    else $error("length byte count out of range");

  // A stalled result stays valid and unchanged until the receiver takes it
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(res_q))
    else $error("stalled result overwritten");

endmodule
